// ===== rtl/cfi_pkg.sv =====
// Shared types, constants and helper functions for the contact friction impulse unit.
// Depends on nothing; imported by the top level.
package cfi_pkg;

    // Fixed field widths of the contact item and datapath sizes.
    localparam int VEL_W      = 32;
    localparam int TAN_W      = 16;
    localparam int MASS_W     = 31;
    localparam int CAP_W      = 32;
    localparam int PROJ_W     = 50;
    localparam int SHIFT_W    = 5;
    localparam int SQRT_STEPS = 32;

    // Configuration register indexes.
    localparam logic [0:0] REG_TIME_STEP     = 1'b0;
    localparam logic [0:0] REG_CONTACT_COUNT = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [15:0] TIME_STEP_RESET = 16'd1092;

    localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

    // Contact data that rides along the whole pipeline.
    typedef struct packed {
        logic [2:0][VEL_W-1:0] vel;
        logic [2:0][TAN_W-1:0] tan1;
        logic [2:0][TAN_W-1:0] tan2;
        logic [MASS_W-1:0]     im;
        logic [CAP_W-1:0]      cap;
        logic                  last;
    } item_t;

    // Side data through the impulse divider.
    typedef struct packed {
        item_t item;
        logic  neg1;
        logic  neg2;
        logic  im_zero;
    } d1_side_t;

    // Side data through the cone test.
    typedef struct packed {
        item_t item;
        logic  neg1;
        logic  neg2;
    } sign_side_t;

    // Side data through the rescaling divider.
    typedef struct packed {
        item_t       item;
        logic        neg1;
        logic        neg2;
        logic        clamped;
        logic [31:0] a_lo;
        logic [31:0] b_lo;
    } d2_side_t;

    // Side data through the square root.
    typedef struct packed {
        d2_side_t    base;
        logic [30:0] a_sh;
        logic [30:0] b_sh;
    } sq_side_t;

    // Saturate a wide signed value to 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        logic signed [31:0] y;
        if (x > 64'sd2147483647)
            y = SAT_MAX;
        else if (x < -64'sd2147483648)
            y = SAT_MIN;
        else
            y = x[31:0];
        return y;
    endfunction

    // Smallest right shift that brings a magnitude below 2^31.
    function automatic logic [SHIFT_W-1:0] norm_shift(input logic [PROJ_W-1:0] x);
        logic [SHIFT_W-1:0] s;
        s = '0;
        for (int i = 31; i < PROJ_W; i++)
        begin
            if (x[i])
                s = SHIFT_W'(i - 30);
        end
        return s;
    endfunction

endpackage

// ===== rtl/contact_friction_impulse_unit.sv =====
// Contact friction impulse unit: Coulomb cone clamp of the tangential impulse.
// Depends on cfi_pkg and cfi_divpipe.
// One item per cycle is taken while no result is held waiting at the output.
// The depth is set by two pipelined dividers (50 and 32 stages) and a 32-stage square root.
// The whole pipeline holds while a result waits at the output; bubbles advance with it.
// Reset clears all valid bits, sets time_step to 1092, contact_count and the index to zero.
module contact_friction_impulse_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] vel_x,
    input  logic signed [31:0] vel_y,
    input  logic signed [31:0] vel_z,
    input  logic signed [15:0] tan1_x,
    input  logic signed [15:0] tan1_y,
    input  logic signed [15:0] tan1_z,
    input  logic signed [15:0] tan2_x,
    input  logic signed [15:0] tan2_y,
    input  logic signed [15:0] tan2_z,
    input  logic [30:0]        normal_force,
    input  logic [30:0]        inverse_mass,
    input  logic [14:0]        friction_coef,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] new_vel_x,
    output logic signed [31:0] new_vel_y,
    output logic signed [31:0] new_vel_z,
    output logic               impulse_clamped,
    output logic               last_contact,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [0:0]         cfg_index,
    input  logic [15:0]        cfg_data
);
    import cfi_pkg::*;

    logic en;

    // Configuration and pass counter.
    logic [15:0] time_step_reg;
    logic [15:0] contact_count_reg;
    logic [15:0] contact_index_reg;
    logic        last_next;
    logic        accept;

    // Stage A1: products.
    logic                      a1_valid_reg;
    item_t                     a1_item_reg;
    logic signed [47:0]        a1_p1_reg [3];
    logic signed [47:0]        a1_p2_reg [3];
    logic [30:0]               a1_ft_reg;
    logic [30:0]               a1_nf_reg;

    // Stage A2: projections and cone limit product.
    logic                      a2_valid_reg;
    item_t                     a2_item_reg;
    logic signed [PROJ_W-1:0]  a2_c1_reg;
    logic signed [PROJ_W-1:0]  a2_c2_reg;
    logic [61:0]               a2_ftn_reg;

    // Impulse divider.
    logic [PROJ_W-1:0]         d1_mag1;
    logic [PROJ_W-1:0]         d1_mag2;
    logic [PROJ_W-1:0]         d1_num1;
    logic [PROJ_W-1:0]         d1_num2;
    d1_side_t                  d1_in_side;
    logic                      d1_out_valid;
    logic [PROJ_W-1:0]         d1_quo1;
    logic [PROJ_W-1:0]         d1_quo2;
    d1_side_t                  d1_out_side;
    logic [PROJ_W-1:0]         b1_a_next;
    logic [PROJ_W-1:0]         b1_b_next;
    sign_side_t                b1_side_next;

    // Stage B1: squares.
    logic                      b1_valid_reg;
    sign_side_t                b1_side_reg;
    logic [PROJ_W-1:0]         b1_a_reg;
    logic [PROJ_W-1:0]         b1_b_reg;
    logic                      b1_big_reg;
    logic [63:0]               b1_a2_reg;
    logic [63:0]               b1_b2_reg;
    logic [63:0]               b1_cc_reg;

    // Stage B2: cone test and normalising shift.
    logic                      b2_valid_reg;
    sign_side_t                b2_side_reg;
    logic [PROJ_W-1:0]         b2_a_reg;
    logic [PROJ_W-1:0]         b2_b_reg;
    logic                      b2_clamped_reg;
    logic [SHIFT_W-1:0]        b2_shift_reg;

    // Stage B3: shifted magnitudes.
    logic [PROJ_W-1:0]         b3_a_sh;
    logic [PROJ_W-1:0]         b3_b_sh;
    sq_side_t                  b3_side_next;
    logic                      b3_valid_reg;
    sq_side_t                  b3_side_reg;

    // Stage B4 and B5: squared length.
    logic                      b4_valid_reg;
    sq_side_t                  b4_side_reg;
    logic [61:0]               b4_a2_reg;
    logic [61:0]               b4_b2_reg;
    logic                      b5_valid_reg;
    sq_side_t                  b5_side_reg;
    logic [62:0]               b5_sq_reg;

    // Square root stages.
    logic                      sq_valid_reg [SQRT_STEPS];
    logic [63:0]               sq_n_reg     [SQRT_STEPS];
    logic [63:0]               sq_r_reg     [SQRT_STEPS];
    sq_side_t                  sq_side_reg  [SQRT_STEPS];

    // Stage M: rescaling products.
    logic [31:0]               m_len_next;
    logic                      m_valid_reg;
    d2_side_t                  m_side_reg;
    logic [62:0]               m_p1_reg;
    logic [62:0]               m_p2_reg;
    logic [31:0]               m_len_reg;

    // Rescaling divider.
    logic                      d2_out_valid;
    logic [31:0]               d2_quo1;
    logic [31:0]               d2_quo2;
    d2_side_t                  d2_out_side;
    logic [31:0]               c0_mag1;
    logic [31:0]               c0_mag2;

    // Stages C0 to C3: momentum and velocity change.
    logic                      c0_valid_reg;
    item_t                     c0_item_reg;
    logic                      c0_clamped_reg;
    logic signed [32:0]        c0_i1_reg;
    logic signed [32:0]        c0_i2_reg;
    logic                      c1_valid_reg;
    item_t                     c1_item_reg;
    logic                      c1_clamped_reg;
    logic signed [48:0]        c1_pm1_reg [3];
    logic signed [48:0]        c1_pm2_reg [3];
    logic signed [PROJ_W-1:0]  c2_p      [3];
    logic                      c2_valid_reg;
    item_t                     c2_item_reg;
    logic                      c2_clamped_reg;
    logic signed [31:0]        c2_pq_reg [3];
    logic                      c3_valid_reg;
    item_t                     c3_item_reg;
    logic                      c3_clamped_reg;
    logic signed [63:0]        c3_dv_reg [3];

    // Output register.
    logic                      out_valid_reg;
    logic signed [31:0]        out_vel_reg [3];
    logic                      out_clamped_reg;
    logic                      out_last_reg;

    // The pipeline advances unless a result is held at the output.
    assign en        = !out_valid_reg || out_ready;
    assign in_ready  = en;
    assign cfg_ready = 1'b1;
    assign accept    = in_valid && en;

    // Last contact of the pass is decided when the item is accepted.
    assign last_next = (contact_count_reg != '0) &&
                       ((contact_index_reg + 16'd1) == contact_count_reg);

    // Configuration registers and pass counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_step_reg     <= TIME_STEP_RESET;
            contact_count_reg <= '0;
            contact_index_reg <= '0;
        end
        else
        begin
            if (accept)
                contact_index_reg <= last_next ? 16'd0 : contact_index_reg + 16'd1;
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_TIME_STEP:
                    begin
                        time_step_reg <= cfg_data;
                    end
                    REG_CONTACT_COUNT:
                    begin
                        contact_count_reg <= cfg_data;
                        contact_index_reg <= '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Valid bits of the stages outside the dividers and the square root.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a1_valid_reg  <= 1'b0;
            a2_valid_reg  <= 1'b0;
            b1_valid_reg  <= 1'b0;
            b2_valid_reg  <= 1'b0;
            b3_valid_reg  <= 1'b0;
            b4_valid_reg  <= 1'b0;
            b5_valid_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
            c0_valid_reg  <= 1'b0;
            c1_valid_reg  <= 1'b0;
            c2_valid_reg  <= 1'b0;
            c3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a1_valid_reg  <= in_valid;
            a2_valid_reg  <= a1_valid_reg;
            b1_valid_reg  <= d1_out_valid;
            b2_valid_reg  <= b1_valid_reg;
            b3_valid_reg  <= b2_valid_reg;
            b4_valid_reg  <= b3_valid_reg;
            b5_valid_reg  <= b4_valid_reg;
            m_valid_reg   <= sq_valid_reg[SQRT_STEPS-1];
            c0_valid_reg  <= d2_out_valid;
            c1_valid_reg  <= c0_valid_reg;
            c2_valid_reg  <= c1_valid_reg;
            c3_valid_reg  <= c2_valid_reg;
            out_valid_reg <= c3_valid_reg;
        end
    end

    // Stage A1: velocity times tangent products and friction times dt.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a1_item_reg.vel  <= {vel_z, vel_y, vel_x};
            a1_item_reg.tan1 <= {tan1_z, tan1_y, tan1_x};
            a1_item_reg.tan2 <= {tan2_z, tan2_y, tan2_x};
            a1_item_reg.im   <= inverse_mass;
            a1_item_reg.cap  <= '0;
            a1_item_reg.last <= last_next;
            a1_p1_reg[0]     <= vel_x * tan1_x;
            a1_p1_reg[1]     <= vel_y * tan1_y;
            a1_p1_reg[2]     <= vel_z * tan1_z;
            a1_p2_reg[0]     <= vel_x * tan2_x;
            a1_p2_reg[1]     <= vel_y * tan2_y;
            a1_p2_reg[2]     <= vel_z * tan2_z;
            a1_ft_reg        <= 31'(friction_coef) * 31'(time_step_reg);
            a1_nf_reg        <= normal_force;
        end
    end

    // Stage A2: tangential projections and the full cone limit product.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a2_item_reg <= a1_item_reg;
            a2_c1_reg   <= PROJ_W'(a1_p1_reg[0]) + PROJ_W'(a1_p1_reg[1])
                           + PROJ_W'(a1_p1_reg[2]);
            a2_c2_reg   <= PROJ_W'(a1_p2_reg[0]) + PROJ_W'(a1_p2_reg[1])
                           + PROJ_W'(a1_p2_reg[2]);
            a2_ftn_reg  <= 62'(a1_ft_reg) * 62'(a1_nf_reg);
        end
    end

    // Divider operands: magnitude of four times the projection, sign of the impulse.
    always_comb
    begin
        d1_mag1 = a2_c1_reg[PROJ_W-1] ? PROJ_W'(-a2_c1_reg) : PROJ_W'(a2_c1_reg);
        d1_mag2 = a2_c2_reg[PROJ_W-1] ? PROJ_W'(-a2_c2_reg) : PROJ_W'(a2_c2_reg);
        d1_num1 = {d1_mag1[PROJ_W-3:0], 2'b00};
        d1_num2 = {d1_mag2[PROJ_W-3:0], 2'b00};
        d1_in_side.item     = a2_item_reg;
        d1_in_side.item.cap = a2_ftn_reg[61:30];
        d1_in_side.neg1     = !a2_c1_reg[PROJ_W-1] && (a2_c1_reg != '0);
        d1_in_side.neg2     = !a2_c2_reg[PROJ_W-1] && (a2_c2_reg != '0);
        d1_in_side.im_zero  = (a2_item_reg.im == '0);
    end

    cfi_divpipe #(
        .NUM_W  (PROJ_W),
        .DEN_W  (MASS_W),
        .SIDE_W ($bits(d1_side_t))
    ) u_impulse_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (a2_valid_reg),
        .in_num0   (d1_num1),
        .in_num1   (d1_num2),
        .in_rem0   ('0),
        .in_rem1   ('0),
        .in_den    (a2_item_reg.im),
        .in_side   (d1_in_side),
        .out_valid (d1_out_valid),
        .out_quo0  (d1_quo1),
        .out_quo1  (d1_quo2),
        .out_side  (d1_out_side)
    );

    // An immovable particle gets no impulse.
    always_comb
    begin
        b1_a_next         = d1_out_side.im_zero ? '0 : d1_quo1;
        b1_b_next         = d1_out_side.im_zero ? '0 : d1_quo2;
        b1_side_next.item = d1_out_side.item;
        b1_side_next.neg1 = d1_out_side.neg1;
        b1_side_next.neg2 = d1_out_side.neg2;
    end

    // Stage B1: squared impulse components and squared limit.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b1_side_reg <= b1_side_next;
            b1_a_reg    <= b1_a_next;
            b1_b_reg    <= b1_b_next;
            b1_big_reg  <= (b1_a_next[PROJ_W-1:32] != '0) || (b1_b_next[PROJ_W-1:32] != '0);
            b1_a2_reg   <= 64'(b1_a_next[31:0]) * 64'(b1_a_next[31:0]);
            b1_b2_reg   <= 64'(b1_b_next[31:0]) * 64'(b1_b_next[31:0]);
            b1_cc_reg   <= 64'(d1_out_side.item.cap) * 64'(d1_out_side.item.cap);
        end
    end

    // Stage B2: cone test and the shift that brings both magnitudes below 2^31.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b2_side_reg    <= b1_side_reg;
            b2_a_reg       <= b1_a_reg;
            b2_b_reg       <= b1_b_reg;
            b2_clamped_reg <= b1_big_reg ||
                              (({1'b0, b1_a2_reg} + {1'b0, b1_b2_reg}) > {1'b0, b1_cc_reg});
            b2_shift_reg   <= norm_shift(b1_a_reg | b1_b_reg);
        end
    end

    // Stage B3: normalised magnitudes.
    always_comb
    begin
        b3_a_sh = b2_a_reg >> b2_shift_reg;
        b3_b_sh = b2_b_reg >> b2_shift_reg;
        b3_side_next.base.item    = b2_side_reg.item;
        b3_side_next.base.neg1    = b2_side_reg.neg1;
        b3_side_next.base.neg2    = b2_side_reg.neg2;
        b3_side_next.base.clamped = b2_clamped_reg;
        b3_side_next.base.a_lo    = b2_a_reg[31:0];
        b3_side_next.base.b_lo    = b2_b_reg[31:0];
        b3_side_next.a_sh         = b3_a_sh[30:0];
        b3_side_next.b_sh         = b3_b_sh[30:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b3_side_reg <= b3_side_next;
        end
    end

    // Stage B4: squares of the normalised magnitudes.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b4_side_reg <= b3_side_reg;
            b4_a2_reg   <= 62'(b3_side_reg.a_sh) * 62'(b3_side_reg.a_sh);
            b4_b2_reg   <= 62'(b3_side_reg.b_sh) * 62'(b3_side_reg.b_sh);
        end
    end

    // Stage B5: squared length.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b5_side_reg <= b4_side_reg;
            b5_sq_reg   <= 63'(b4_a2_reg) + 63'(b4_b2_reg);
        end
    end

    // Square root, one result bit per stage.
    for (genvar j = 0; j < SQRT_STEPS; j++)
    begin : g_sqrt
        localparam logic [63:0] ROOT_BIT = 64'd1 << (62 - 2 * j);
        logic        v_in;
        logic [63:0] n_in;
        logic [63:0] r_in;
        sq_side_t    side_in;
        logic [63:0] trial;
        logic        fits;

        if (j == 0)
        begin : g_first
            assign v_in    = b5_valid_reg;
            assign n_in    = {1'b0, b5_sq_reg};
            assign r_in    = '0;
            assign side_in = b5_side_reg;
        end
        else
        begin : g_rest
            assign v_in    = sq_valid_reg[j-1];
            assign n_in    = sq_n_reg[j-1];
            assign r_in    = sq_r_reg[j-1];
            assign side_in = sq_side_reg[j-1];
        end

        assign trial = r_in + ROOT_BIT;
        assign fits  = (n_in >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sq_valid_reg[j] <= 1'b0;
            else if (en)
                sq_valid_reg[j] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_n_reg[j]    <= fits ? n_in - trial : n_in;
                sq_r_reg[j]    <= fits ? (r_in >> 1) + ROOT_BIT : r_in >> 1;
                sq_side_reg[j] <= side_in;
            end
        end
    end

    // A zero length is taken as one.
    assign m_len_next = (sq_r_reg[SQRT_STEPS-1][31:0] == '0) ? 32'd1
                                                             : sq_r_reg[SQRT_STEPS-1][31:0];

    // Stage M: normalised magnitude times the limit.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_side_reg <= sq_side_reg[SQRT_STEPS-1].base;
            m_p1_reg   <= 63'(sq_side_reg[SQRT_STEPS-1].a_sh)
                          * 63'(sq_side_reg[SQRT_STEPS-1].base.item.cap);
            m_p2_reg   <= 63'(sq_side_reg[SQRT_STEPS-1].b_sh)
                          * 63'(sq_side_reg[SQRT_STEPS-1].base.item.cap);
            m_len_reg  <= m_len_next;
        end
    end

    // The quotient never exceeds the limit, so the upper half starts as remainder.
    cfi_divpipe #(
        .NUM_W  (32),
        .DEN_W  (32),
        .SIDE_W ($bits(d2_side_t))
    ) u_rescale_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (m_valid_reg),
        .in_num0   (m_p1_reg[31:0]),
        .in_num1   (m_p2_reg[31:0]),
        .in_rem0   ({1'b0, m_p1_reg[62:32]}),
        .in_rem1   ({1'b0, m_p2_reg[62:32]}),
        .in_den    (m_len_reg),
        .in_side   (m_side_reg),
        .out_valid (d2_out_valid),
        .out_quo0  (d2_quo1),
        .out_quo1  (d2_quo2),
        .out_side  (d2_out_side)
    );

    assign c0_mag1 = d2_out_side.clamped ? d2_quo1 : d2_out_side.a_lo;
    assign c0_mag2 = d2_out_side.clamped ? d2_quo2 : d2_out_side.b_lo;

    // Stage C0: signed tangential impulse.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c0_item_reg    <= d2_out_side.item;
            c0_clamped_reg <= d2_out_side.clamped;
            c0_i1_reg      <= d2_out_side.neg1 ? -$signed({1'b0, c0_mag1})
                                               : $signed({1'b0, c0_mag1});
            c0_i2_reg      <= d2_out_side.neg2 ? -$signed({1'b0, c0_mag2})
                                               : $signed({1'b0, c0_mag2});
        end
    end

    // Stage C1: impulse mapped back along each tangent.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c1_item_reg    <= c0_item_reg;
            c1_clamped_reg <= c0_clamped_reg;
            for (int k = 0; k < 3; k++)
            begin
                c1_pm1_reg[k] <= c0_i1_reg * $signed(c0_item_reg.tan1[k]);
                c1_pm2_reg[k] <= c0_i2_reg * $signed(c0_item_reg.tan2[k]);
            end
        end
    end

    // Stage C2: momentum per axis, floored to Q16.16 and saturated.
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            c2_p[k] = PROJ_W'(c1_pm1_reg[k]) + PROJ_W'(c1_pm2_reg[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c2_item_reg    <= c1_item_reg;
            c2_clamped_reg <= c1_clamped_reg;
            for (int k = 0; k < 3; k++)
            begin
                c2_pq_reg[k] <= sat32(64'(c2_p[k] >>> 14));
            end
        end
    end

    // Stage C3: inverse mass times momentum.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c3_item_reg    <= c2_item_reg;
            c3_clamped_reg <= c2_clamped_reg;
            for (int k = 0; k < 3; k++)
            begin
                c3_dv_reg[k] <= $signed({1'b0, c2_item_reg.im}) * c2_pq_reg[k];
            end
        end
    end

    // Output register: velocity plus floored change, saturated.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_clamped_reg <= c3_clamped_reg;
            out_last_reg    <= c3_item_reg.last;
            for (int k = 0; k < 3; k++)
            begin
                out_vel_reg[k] <= sat32(64'($signed(c3_item_reg.vel[k]))
                                        + (c3_dv_reg[k] >>> 16));
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign new_vel_x       = out_vel_reg[0];
    assign new_vel_y       = out_vel_reg[1];
    assign new_vel_z       = out_vel_reg[2];
    assign impulse_clamped = out_clamped_reg;
    assign last_contact    = out_last_reg;

endmodule

// ===== rtl/cfi_divpipe.sv =====
// Pipelined restoring divider, one quotient bit per stage, two lanes sharing a divisor.
// Standalone; used twice by the contact friction impulse top level.
module cfi_divpipe #(
    parameter int NUM_W  = 50,
    parameter int DEN_W  = 31,
    parameter int SIDE_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [NUM_W-1:0]  in_num0,
    input  logic [NUM_W-1:0]  in_num1,
    input  logic [DEN_W-1:0]  in_rem0,
    input  logic [DEN_W-1:0]  in_rem1,
    input  logic [DEN_W-1:0]  in_den,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [NUM_W-1:0]  out_quo0,
    output logic [NUM_W-1:0]  out_quo1,
    output logic [SIDE_W-1:0] out_side
);

    // One step: shift in the next dividend bit, subtract if it fits.
    function automatic logic [DEN_W+NUM_W-1:0] div_step(
        input logic [DEN_W-1:0] rem,
        input logic [NUM_W-1:0] num,
        input logic [DEN_W-1:0] den
    );
        logic [DEN_W:0] t;
        logic [DEN_W:0] d;
        logic           ge;
        t  = {rem, num[NUM_W-1]};
        d  = t - {1'b0, den};
        ge = (t >= {1'b0, den});
        return {(ge ? d[DEN_W-1:0] : t[DEN_W-1:0]), num[NUM_W-2:0], ge};
    endfunction

    logic              valid_reg [NUM_W];
    logic [NUM_W-1:0]  num0_reg  [NUM_W];
    logic [NUM_W-1:0]  num1_reg  [NUM_W];
    logic [DEN_W-1:0]  rem0_reg  [NUM_W];
    logic [DEN_W-1:0]  rem1_reg  [NUM_W];
    logic [DEN_W-1:0]  den_reg   [NUM_W];
    logic [SIDE_W-1:0] side_reg  [NUM_W];

    for (genvar j = 0; j < NUM_W; j++)
    begin : g_step
        logic              v_in;
        logic [NUM_W-1:0]  num0_in;
        logic [NUM_W-1:0]  num1_in;
        logic [DEN_W-1:0]  rem0_in;
        logic [DEN_W-1:0]  rem1_in;
        logic [DEN_W-1:0]  den_in;
        logic [SIDE_W-1:0] side_in;
        logic [NUM_W-1:0]  num0_next;
        logic [NUM_W-1:0]  num1_next;
        logic [DEN_W-1:0]  rem0_next;
        logic [DEN_W-1:0]  rem1_next;

        if (j == 0)
        begin : g_first
            assign v_in    = in_valid;
            assign num0_in = in_num0;
            assign num1_in = in_num1;
            assign rem0_in = in_rem0;
            assign rem1_in = in_rem1;
            assign den_in  = in_den;
            assign side_in = in_side;
        end
        else
        begin : g_rest
            assign v_in    = valid_reg[j-1];
            assign num0_in = num0_reg[j-1];
            assign num1_in = num1_reg[j-1];
            assign rem0_in = rem0_reg[j-1];
            assign rem1_in = rem1_reg[j-1];
            assign den_in  = den_reg[j-1];
            assign side_in = side_reg[j-1];
        end

        assign {rem0_next, num0_next} = div_step(rem0_in, num0_in, den_in);
        assign {rem1_next, num1_next} = div_step(rem1_in, num1_in, den_in);

        // Valid bit of this stage.
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[j] <= 1'b0;
            else if (en)
                valid_reg[j] <= v_in;
        end

        // Partial remainders, quotient bits and side data.
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                num0_reg[j] <= num0_next;
                num1_reg[j] <= num1_next;
                rem0_reg[j] <= rem0_next;
                rem1_reg[j] <= rem1_next;
                den_reg[j]  <= den_in;
                side_reg[j] <= side_in;
            end
        end
    end

    assign out_valid = valid_reg[NUM_W-1];
    assign out_quo0  = num0_reg[NUM_W-1];
    assign out_quo1  = num1_reg[NUM_W-1];
    assign out_side  = side_reg[NUM_W-1];

endmodule
